@@ rtl/bhpq_pkg.sv @@
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; used by binary_min_heap_priority_queue.
package bhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int TAG_W        = 8;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int DEF_CAPACITY = 1024;

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

@@ rtl/binary_min_heap_priority_queue.sv @@
// Binary min-heap priority queue: sequencer, entry memory and shared key comparator.
// Depends on bhpq_pkg (types, command and status codes).
//
// Array min-heap of (key, tag) entries, root at slot 1, held in one single-port-write,
// single-read memory of CAPACITY entries with registered read data. A request is taken
// when start is high and busy is low; each request gives exactly one result, shown on
// out_status/out_key/out_tag for one cycle with out_valid high. The receiver cannot stall.
// Keys are unsigned 16.16 fixed point; smaller keys are served first, ties never swap.
// Sequence (one memory read per cycle, one key comparator shared by all levels):
//   clear, unused command, insert when full, extract when empty: result strobed in the
//     cycle after the request is taken.
//   insert: the hole starts at the new last slot and climbs at most log2(CAPACITY)
//     levels, one per read-and-compare pair (S_UP_RD, S_UP_CMP); the entry is written at
//     the root or below the first parent whose key is not larger.
//   extract: read the root (S_EX_ROOT), then the last entry (S_EX_LAST), which becomes
//     the sinking entry (S_EX_MOVE); with at most one entry left it is written at the
//     root and the result strobed. Otherwise each level descended reads both children
//     through the one read port and compares each against the best so far, until the
//     entry settles at a leaf or above its children. busy drops in the cycle the
//   result is strobed, so the next request can be taken there.
// No clearing pass: data read from slots beyond the entry count is never used.

module binary_min_heap_priority_queue #(
  parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bhpq_pkg::CMD_W-1:0]   in_command,
  input  logic [bhpq_pkg::KEY_W-1:0]   in_key,
  input  logic [bhpq_pkg::TAG_W-1:0]   in_tag,
  output logic                         out_valid,
  output logic [bhpq_pkg::STAT_W-1:0]  out_status,
  output logic [bhpq_pkg::KEY_W-1:0]   out_key,
  output logic [bhpq_pkg::TAG_W-1:0]   out_tag
);

  // slot numbers run 1..CAPACITY; memory address is slot - 1
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SLOT_W-1:0] CAP_SLOT = SLOT_W'(CAPACITY);
  localparam logic [SLOT_W-1:0] ROOT     = SLOT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,    // issue parent read, or settle at the root
    S_UP_CMP,   // parent data back: move parent down or settle
    S_EX_ROOT,  // read root
    S_EX_LAST,  // capture root, read last entry
    S_EX_MOVE,  // last entry becomes the sinking entry
    S_DN_RD1,   // issue read of right child (2i+1), or left if none; settle at a leaf
    S_DN_RD0,   // right child back; issue read of left child (2i)
    S_DN_CMP    // left child back: pick the winner
  } state_t;

  state_t                       state_r, state_nxt;
  logic [SLOT_W-1:0]            count_r, count_nxt;
  logic [SLOT_W-1:0]            pos_r, pos_nxt;      // current hole
  bhpq_pkg::entry_t             x_r, x_nxt;          // entry being placed
  bhpq_pkg::entry_t             best_r, best_nxt;    // best of x and right child
  logic                         best_c1_r, best_c1_nxt;
  bhpq_pkg::entry_t             root_r, root_nxt;    // extracted entry
  logic                         out_valid_r, out_valid_nxt;
  logic [bhpq_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [bhpq_pkg::KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [bhpq_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;

  // entry memory
  bhpq_pkg::entry_t             mem [CAPACITY];
  bhpq_pkg::entry_t             rd_data_r;
  logic [SLOT_W:0]              rd_slot, rd_slot_m1;
  logic [SLOT_W-1:0]            wr_slot, wr_slot_m1;
  logic                         wr_en;
  bhpq_pkg::entry_t             wr_data;

  // shared comparator
  logic [bhpq_pkg::KEY_W-1:0]   cmp_lhs, cmp_rhs;
  logic                         cmp_lt;

  // children of the hole, one bit wider so they cannot wrap
  logic [SLOT_W:0]              c0_slot, c1_slot, count_ext;
  logic                         c0_ok, c1_ok;

  assign count_ext = {1'b0, count_r};
  assign c0_slot   = {pos_r, 1'b0};
  assign c1_slot   = {pos_r, 1'b1};
  assign c0_ok     = (c0_slot <= count_ext);
  assign c1_ok     = (c1_slot <= count_ext);

  assign cmp_lt     = (cmp_lhs < cmp_rhs);
  assign rd_slot_m1 = rd_slot - 1'b1;
  assign wr_slot_m1 = wr_slot - 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot_m1[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_slot_m1[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    x_nxt          = x_r;
    best_nxt       = best_r;
    best_c1_nxt    = best_c1_r;
    root_nxt       = root_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    rd_slot        = {1'b0, ROOT};
    wr_en          = 1'b0;
    wr_slot        = pos_r;
    wr_data        = x_r;
    cmp_lhs        = x_r.key;
    cmp_rhs        = rd_data_r.key;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          // default result: ok with zero payload
          out_status_nxt = bhpq_pkg::ST_OK;
          out_key_nxt    = '0;
          out_tag_nxt    = '0;
          case (in_command)
            bhpq_pkg::CMD_INSERT: begin
              if (count_r == CAP_SLOT) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bhpq_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                pos_nxt   = count_r + 1'b1;
                x_nxt     = '{key: in_key, tag: in_tag};
                state_nxt = S_UP_RD;
              end
            end
            bhpq_pkg::CMD_EXTRACT: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bhpq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_EX_ROOT;
              end
            end
            bhpq_pkg::CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_r == ROOT) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_slot   = {1'b0, (pos_r >> 1)};
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_lhs = x_r.key;
        cmp_rhs = rd_data_r.key;
        wr_en   = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data_r;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_EX_ROOT: begin
        rd_slot   = {1'b0, ROOT};
        state_nxt = S_EX_LAST;
      end

      S_EX_LAST: begin
        rd_slot   = count_ext;
        root_nxt  = rd_data_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_EX_MOVE;
      end

      S_EX_MOVE: begin
        x_nxt = rd_data_r;
        if (count_r <= ROOT) begin
          // zero or one left: no sifting, last entry lands at the root if any
          wr_en          = (count_r == ROOT);
          wr_slot        = ROOT;
          wr_data        = rd_data_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_key_nxt    = root_r.key;
          out_tag_nxt    = root_r.tag;
          state_nxt      = S_IDLE;
        end else begin
          pos_nxt   = ROOT;
          state_nxt = S_DN_RD1;
        end
      end

      S_DN_RD1: begin
        if (!c0_ok) begin
          // leaf: settle here
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_key_nxt    = root_r.key;
          out_tag_nxt    = root_r.tag;
          state_nxt      = S_IDLE;
        end else begin
          rd_slot   = c1_ok ? c1_slot : c0_slot;
          state_nxt = S_DN_RD0;
        end
      end

      S_DN_RD0: begin
        rd_slot = c0_slot;
        cmp_lhs = rd_data_r.key;
        cmp_rhs = x_r.key;
        if (c1_ok && cmp_lt) begin
          best_nxt    = rd_data_r;
          best_c1_nxt = 1'b1;
        end else begin
          best_nxt    = x_r;
          best_c1_nxt = 1'b0;
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_lhs = rd_data_r.key;
        cmp_rhs = best_r.key;
        wr_en   = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data_r;
          pos_nxt   = c0_slot[SLOT_W-1:0];
          state_nxt = S_DN_RD1;
        end else if (best_c1_r) begin
          wr_data   = best_r;
          pos_nxt   = c1_slot[SLOT_W-1:0];
          state_nxt = S_DN_RD1;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_key_nxt    = root_r.key;
          out_tag_nxt    = root_r.tag;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    x_r          <= x_nxt;
    best_r       <= best_nxt;
    best_c1_r    <= best_c1_nxt;
    root_r       <= root_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_tag    = out_tag_r;

  // ---------------------------------------------------------------------------
  // Assertions

  // fill level never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_SLOT)
    else $error("entry count above capacity");

  // clear gives an ok result on the next cycle and empties the heap
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == bhpq_pkg::CMD_CLEAR)
      |=> (out_valid && out_status == bhpq_pkg::ST_OK && count_r == '0))
    else $error("clear did not complete");

  // error results carry a zero payload (as do all results but a successful extract)
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bhpq_pkg::ST_OK) |-> (out_key == '0 && out_tag == '0))
    else $error("error result with non-zero payload");

  // the hole stays inside the filled part of the heap while sifting
  a_hole_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_RD || state_r == S_UP_CMP || state_r == S_DN_RD1 ||
     state_r == S_DN_RD0 || state_r == S_DN_CMP)
      |-> (pos_r != '0 && pos_r <= count_r))
    else $error("heap hole out of range");

  // a result ends every request: no strobe while a request is in flight
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result strobed mid-request");

endmodule
